[hw/rtl/png_unf_pkg.sv]
// Shared types and constants for the PNG scanline unfilter unit.
// Depends on nothing; imported by png_scanline_unfilter_unit.
package png_unf_pkg;

	// Configuration port
	localparam int CFG_DATA_W = 14;
	localparam int CFG_ADDR_W = 1;

	localparam logic [CFG_ADDR_W-1:0] REG_BYTES_PER_PIXEL = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_LINE_BYTES      = 1'd1;

	// Filter type codes
	localparam logic [2:0] FILT_NONE  = 3'd0;
	localparam logic [2:0] FILT_SUB   = 3'd1;
	localparam logic [2:0] FILT_UP    = 3'd2;
	localparam logic [2:0] FILT_AVG   = 3'd3;
	localparam logic [2:0] FILT_PAETH = 3'd4;

	localparam logic [7:0] FILT_MAX_CODE = 8'd4;

	// Result status codes
	localparam logic STAT_OK         = 1'b0;
	localparam logic STAT_BAD_FILTER = 1'b1;

	// Work carried by the reconstruct stage
	typedef enum logic [1:0] {
		OP_CLR,   // filter byte: clear windows, no result
		OP_ERR,   // invalid filter type: error result
		OP_DATA   // filtered data byte: reconstruct
	} op_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       image_start;
	} in_item_t;

	typedef struct packed {
		logic [7:0] pixel_byte;
		logic       row_end;
		logic       status;
	} out_item_t;

endpackage

[hw/rtl/png_scanline_unfilter_unit.sv]
// PNG scanline unfilter: rebuilds raw image bytes from the inflated stream.
// Depends on png_unf_pkg and png_unf_ram.
//
// The unit takes one stream byte per clock while the output is not stalled,
// and gives one raw byte per data byte via the stage and result registers.
// The first byte of each row is the filter type (none, sub, up, average,
// Paeth); it produces no result but still takes one input slot. A filter
// type above Paeth gives one error result (status 1, zero byte) and the
// unit drops data until a byte marked image_start arrives. image_start
// always starts a new first row, whose row above reads as zeros. The rate
// is one transaction per cycle while the output is not stalled, set by the
// combinational reconstruct stage between the registered read of the
// prior-row RAM and the result register. The row store has no reset: a row
// longer than any row written before gives undefined bytes above. Configure
// bytes_per_pixel and line_bytes only while the unit is idle.
module png_scanline_unfilter_unit
	import png_unf_pkg::*;
#(
	parameter int MAX_LINE_BYTES  = 8192,
	parameter int MAX_PIXEL_BYTES = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	// stream in
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	// raw bytes out
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data
);

	localparam int ADDR_W = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;
	localparam int COL_W  = $clog2(MAX_LINE_BYTES + 1);
	localparam int CMP_W  = (COL_W > CFG_DATA_W) ? COL_W : CFG_DATA_W;
	localparam int PB_W   = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

	// Paeth predictor: pick the neighbor closest to a + b - c.
	function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c);
		logic signed [10:0] da, db, dc;
		logic [9:0] pa, pb, pc;
		begin
			da = $signed({3'b000, b}) - $signed({3'b000, c});
			db = $signed({3'b000, a}) - $signed({3'b000, c});
			dc = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({2'b00, c, 1'b0});
			pa = da[10] ? 10'(-da) : da[9:0];
			pb = db[10] ? 10'(-db) : db[9:0];
			pc = dc[10] ? 10'(-dc) : dc[9:0];
			if (pa <= pb && pa <= pc) begin
				paeth_pick = a;
			end else if (pb <= pc) begin
				paeth_pick = b;
			end else begin
				paeth_pick = c;
			end
		end
	endfunction

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [3:0]            bpp_q;
	logic [CFG_DATA_W-1:0] line_bytes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q        <= 4'd1;
			line_bytes_q <= CFG_DATA_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_BYTES_PER_PIXEL: bpp_q <= cfg_wdata[3:0];
				REG_LINE_BYTES:      line_bytes_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Clamped row length, 1..MAX_LINE_BYTES
	logic [CMP_W-1:0] len_eff;
	always_comb begin
		if (line_bytes_q == '0) begin
			len_eff = CMP_W'(1);
		end else if (CMP_W'(line_bytes_q) > CMP_W'(MAX_LINE_BYTES)) begin
			len_eff = CMP_W'(MAX_LINE_BYTES);
		end else begin
			len_eff = CMP_W'(line_bytes_q);
		end
	end

	// Left neighbor distance as a window index, bytes_per_pixel - 1
	logic [PB_W-1:0] bpp_idx;
	always_comb begin
		if (bpp_q == 4'd0) begin
			bpp_idx = '0;
		end else if (32'(bpp_q) > MAX_PIXEL_BYTES) begin
			bpp_idx = PB_W'(MAX_PIXEL_BYTES - 1);
		end else begin
			bpp_idx = PB_W'(bpp_q - 4'd1);
		end
	end

	// ---------------------------------------------------------------
	// Front end: row sequencing, decided at acceptance
	// ---------------------------------------------------------------
	logic [COL_W-1:0] col_q;      // 0: expect filter byte, k: next data at k-1
	logic [2:0]       filter_q;
	logic             first_row_q;
	logic             hold_q;

	// reconstruct stage
	logic             s1_valid_q;
	op_t              s1_op_s1;
	logic [7:0]       s1_byte_s1;
	logic [2:0]       s1_filter_s1;
	logic             s1_first_s1;
	logic             s1_last_s1;
	logic [ADDR_W-1:0] s1_pos_s1;

	logic             out_valid_q;
	out_item_t        out_data_q;

	logic s1_go;
	logic accept;
	logic load_s1;
	op_t  load_op;
	logic load_last;
	logic [ADDR_W-1:0] load_pos;

	// A filter byte leaves the stage without a result, so it never waits.
	assign s1_go    = s1_valid_q && (s1_op_s1 == OP_CLR || !out_valid_q || !out_stall);
	assign in_stall = s1_valid_q && !s1_go;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		load_s1   = 1'b0;
		load_op   = OP_CLR;
		load_last = 1'b0;
		load_pos  = ADDR_W'(col_q - COL_W'(1));
		if (accept && (in_data.image_start || !hold_q)) begin
			load_s1 = 1'b1;
			if (in_data.image_start || col_q == '0) begin
				load_op = (in_data.data_byte > FILT_MAX_CODE) ? OP_ERR : OP_CLR;
			end else begin
				load_op   = OP_DATA;
				load_last = CMP_W'(col_q) >= len_eff;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			filter_q    <= FILT_NONE;
			first_row_q <= 1'b1;
			hold_q      <= 1'b0;
		end else if (load_s1) begin
			if (in_data.image_start) begin
				first_row_q <= 1'b1;
			end
			unique case (load_op)
				OP_ERR: begin
					col_q  <= '0;
					hold_q <= 1'b1;
				end
				OP_CLR: begin
					col_q    <= COL_W'(1);
					filter_q <= in_data.data_byte[2:0];
					hold_q   <= 1'b0;
				end
				OP_DATA: begin
					if (load_last) begin
						col_q       <= '0;
						first_row_q <= 1'b0;
					end else begin
						col_q <= col_q + COL_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Prior row store: read at acceptance, written when the byte leaves
	// ---------------------------------------------------------------
	logic [7:0] above_rd;
	logic [7:0] recon;
	logic       ram_we;

	assign ram_we = s1_go && s1_op_s1 == OP_DATA;

	png_unf_ram #(
		.WIDTH (8),
		.DEPTH (MAX_LINE_BYTES),
		.ADDR_W(ADDR_W)
	) u_prior_row (
		.clk  (clk),
		.we   (ram_we),
		.waddr(s1_pos_s1),
		.wdata(recon),
		.re   (load_s1 && load_op == OP_DATA),
		.raddr(load_pos),
		.rdata(above_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (load_s1) begin
			s1_valid_q <= 1'b1;
		end else if (s1_go) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			s1_op_s1     <= load_op;
			s1_byte_s1   <= in_data.data_byte;
			s1_filter_s1 <= filter_q;
			s1_first_s1  <= first_row_q;
			s1_last_s1   <= load_last;
			s1_pos_s1    <= load_pos;
		end
	end

	// ---------------------------------------------------------------
	// Reconstruct stage
	// ---------------------------------------------------------------
	logic [7:0] left_q [MAX_PIXEL_BYTES];   // left_q[0] is the newest byte
	logic [7:0] upleft_q [MAX_PIXEL_BYTES];
	logic [7:0] nb_a, nb_b, nb_c, pred;
	logic [8:0] ab_sum;

	assign nb_a   = left_q[bpp_idx];
	assign nb_b   = s1_first_s1 ? 8'd0 : above_rd;
	assign nb_c   = upleft_q[bpp_idx];
	assign ab_sum = {1'b0, nb_a} + {1'b0, nb_b};

	always_comb begin
		unique case (s1_filter_s1)
			FILT_SUB:   pred = nb_a;
			FILT_UP:    pred = nb_b;
			FILT_AVG:   pred = ab_sum[8:1];
			FILT_PAETH: pred = paeth_pick(nb_a, nb_b, nb_c);
			default:    pred = 8'd0;
		endcase
	end

	assign recon = s1_byte_s1 + pred;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
				left_q[i]   <= 8'd0;
				upleft_q[i] <= 8'd0;
			end
		end else if (s1_go) begin
			if (s1_op_s1 == OP_CLR) begin
				for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
					left_q[i]   <= 8'd0;
					upleft_q[i] <= 8'd0;
				end
			end else if (s1_op_s1 == OP_DATA) begin
				left_q[0]   <= recon;
				upleft_q[0] <= nb_b;
				for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
					left_q[i]   <= left_q[i-1];
					upleft_q[i] <= upleft_q[i-1];
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Result register
	// ---------------------------------------------------------------
	logic out_load;
	assign out_load = s1_go && s1_op_s1 != OP_CLR;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (s1_op_s1 == OP_ERR) begin
				out_data_q.pixel_byte <= 8'd0;
				out_data_q.row_end    <= 1'b0;
				out_data_q.status     <= STAT_BAD_FILTER;
			end else begin
				out_data_q.pixel_byte <= recon;
				out_data_q.row_end    <= s1_last_s1;
				out_data_q.status     <= STAT_OK;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

[hw/rtl/png_unf_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing; used for the prior row store.
module png_unf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
